/* rtl/clbp_pkg.sv */
// Shared types, constants and sampling tables for the circular LBP block.
`timescale 1ns / 1ps

package clbp_pkg;

	localparam int PIX_W       = 8;
	localparam int MAX_WIDTH   = 1024;
	localparam int COL_W       = 10;
	localparam int ROW_W       = 12;
	localparam int STORE_ROWS  = 2;
	localparam int SPAN        = 3;
	localparam int WIN_SIZE    = SPAN * SPAN;
	localparam int CENTRE_IDX  = WIN_SIZE / 2;
	localparam int NEIGHBORS   = 8;
	localparam int TAPS        = 4;
	localparam int TAP_IDX_W   = 4;
	localparam int WGT_FRAC    = 8;
	localparam int WGT_W       = WGT_FRAC + 1;
	localparam int SAMPLE_W    = PIX_W + WGT_FRAC;
	localparam int SUM_W       = SAMPLE_W + 2;
	localparam int CODE_W      = 8;
	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 1;
	localparam int IMG_W_REG_W = 11;
	localparam int IMG_H_REG_W = 13;

	// Row and column limits are kept as "last index" values.
	localparam logic [COL_W-1:0] COL_LAST_MIN = COL_W'(SPAN - 1);
	localparam logic [COL_W-1:0] COL_LAST_MAX = COL_W'(MAX_WIDTH - 1);
	localparam logic [COL_W-1:0] COL_LAST_RST = COL_W'(639);
	localparam logic [ROW_W-1:0] ROW_LAST_MIN = ROW_W'(2);
	localparam logic [ROW_W-1:0] ROW_LAST_MAX = ROW_W'(4095);
	localparam logic [ROW_W-1:0] ROW_LAST_RST = ROW_W'(479);
	localparam logic [IMG_W_REG_W-1:0] IMG_W_MIN = IMG_W_REG_W'(SPAN);
	localparam logic [IMG_W_REG_W-1:0] IMG_W_MAX = IMG_W_REG_W'(MAX_WIDTH);
	localparam logic [IMG_H_REG_W-1:0] IMG_H_MIN = IMG_H_REG_W'(SPAN);
	localparam logic [IMG_H_REG_W-1:0] IMG_H_MAX = IMG_H_REG_W'(4096);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [WIN_SIZE-1:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic last_row;
		logic last_frame;
	} tag_t;

	// Window index (row-major, top row oldest) of the four pixels around each
	// sample point, in the order floor/floor, floor/ceil, ceil/floor, ceil/ceil.
	localparam logic [TAP_IDX_W-1:0] TAP_IDX [NEIGHBORS][TAPS] = '{
		'{4'd7, 4'd7, 4'd7, 4'd7},
		'{4'd3, 4'd4, 4'd6, 4'd7},
		'{4'd3, 4'd3, 4'd3, 4'd3},
		'{4'd0, 4'd1, 4'd3, 4'd4},
		'{4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd4, 4'd5},
		'{4'd5, 4'd5, 4'd5, 4'd5},
		'{4'd4, 4'd5, 4'd7, 4'd8}
	};

	// Bilinear weights with eight fraction bits; each row sums to one.
	localparam logic [WGT_W-1:0] TAP_WGT [NEIGHBORS][TAPS] = '{
		'{9'd256, 9'd0,   9'd0,   9'd0  },
		'{9'd53,  9'd22,  9'd128, 9'd53 },
		'{9'd256, 9'd0,   9'd0,   9'd0  },
		'{9'd128, 9'd53,  9'd53,  9'd22 },
		'{9'd256, 9'd0,   9'd0,   9'd0  },
		'{9'd53,  9'd128, 9'd22,  9'd53 },
		'{9'd256, 9'd0,   9'd0,   9'd0  },
		'{9'd22,  9'd53,  9'd53,  9'd128}
	};

endpackage

/* rtl/clbp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module clbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/clbp_window.sv */
// Raster counters, line store read-modify-write and the 3x3 pixel window.
`timescale 1ns / 1ps

module clbp_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [clbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clbp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  clbp_pkg::pix_t                in_pixel,
	output logic                          win_valid,
	input  logic                          win_ready,
	output clbp_pkg::win_t                win,
	output clbp_pkg::tag_t                win_tag
);

	import clbp_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_last_q;
	logic [ROW_W-1:0] row_last_q;

	logic             valid_s1;
	pix_t             px_s1;
	logic [COL_W-1:0] addr_s1;
	logic             produce_s1;
	tag_t             tag_s1;

	logic             valid_s2;
	tag_t             tag_s2;
	win_t             window_q;

	logic                          accept;
	logic                          adv1;
	logic                          s2_free;
	logic                          row_end;
	logic                          frame_end;
	logic [PIX_W*STORE_ROWS-1:0]   ram_rdata;
	logic [PIX_W*STORE_ROWS-1:0]   ram_wdata;
	logic [IMG_W_REG_W-1:0]        cfg_w;
	logic [IMG_H_REG_W-1:0]        cfg_h;
	logic [COL_W-1:0]              col_last_d;
	logic [ROW_W-1:0]              row_last_d;

	assign s2_free  = !valid_s2 || win_ready;
	assign adv1     = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign accept   = in_valid && in_ready;

	assign row_end   = (col_q == col_last_q);
	assign frame_end = row_end && (row_q >= row_last_q);

	// Clamp the written size and keep it as the index of the last pixel.
	always_comb begin
		cfg_w = cfg_data[IMG_W_REG_W-1:0];
		cfg_h = cfg_data[IMG_H_REG_W-1:0];
		if (cfg_w < IMG_W_MIN) begin
			col_last_d = COL_LAST_MIN;
		end else if (cfg_w > IMG_W_MAX) begin
			col_last_d = COL_LAST_MAX;
		end else begin
			col_last_d = COL_W'(cfg_w - IMG_W_REG_W'(1));
		end
		if (cfg_h < IMG_H_MIN) begin
			row_last_d = ROW_LAST_MIN;
		end else if (cfg_h > IMG_H_MAX) begin
			row_last_d = ROW_LAST_MAX;
		end else begin
			row_last_d = ROW_W'(cfg_h - IMG_H_REG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			col_last_q <= COL_LAST_RST;
			row_last_q <= ROW_LAST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					col_last_q <= col_last_d;
					col_q      <= '0;
					row_q      <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					row_last_q <= row_last_d;
					col_q      <= '0;
					row_q      <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Each entry holds one column of the two stored rows, older row in the low byte.
	clbp_ram #(
		.WIDTH (PIX_W * STORE_ROWS),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (adv1),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign ram_wdata = {px_s1, ram_rdata[PIX_W*STORE_ROWS-1:PIX_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= in_pixel;
			addr_s1    <= col_q;
			produce_s1 <= (row_q >= ROW_W'(STORE_ROWS)) && (col_q >= COL_W'(STORE_ROWS));
			tag_s1     <= '{last_row: row_end, last_frame: frame_end};
		end
	end

	// The window shifts for every pixel, border pixels included.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			for (int y = 0; y < SPAN; y++) begin
				for (int x = 0; x < SPAN - 1; x++) begin
					window_q[y*SPAN+x] <= window_q[y*SPAN+x+1];
				end
			end
			window_q[SPAN-1]          <= ram_rdata[PIX_W-1:0];
			window_q[2*SPAN-1]        <= ram_rdata[PIX_W*STORE_ROWS-1:PIX_W];
			window_q[WIN_SIZE-1]      <= px_s1;
			valid_s2                  <= produce_s1;
		end else if (win_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			tag_s2 <= tag_s1;
		end
	end

	assign win_valid = valid_s2;
	assign win       = window_q;
	assign win_tag   = tag_s2;

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && accept) |-> (addr_s1 != col_q))
		else $error("line store read and write hit the same column");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= col_last_q)
		else $error("column counter past the last pixel of the row");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= row_last_q)
		else $error("row counter past the last row of the frame");

endmodule

/* rtl/clbp_sample.sv */
// Bilinear sample sums and the code compare, with the output register.
`timescale 1ns / 1ps

module clbp_sample (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        win_valid,
	output logic                        win_ready,
	input  clbp_pkg::win_t              win,
	input  clbp_pkg::tag_t              win_tag,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [clbp_pkg::CODE_W-1:0] out_code,
	output logic                        out_last_row,
	output logic                        out_last_frame
);

	import clbp_pkg::*;

	logic                valid_s3;
	logic [SAMPLE_W-1:0] sum_s3 [NEIGHBORS];
	pix_t                centre_s3;
	tag_t                tag_s3;

	logic                out_valid_q;
	logic [CODE_W-1:0]   code_q;
	tag_t                tag_q;

	logic                out_free;
	logic                s3_free;
	logic [SAMPLE_W-1:0] sum_d [NEIGHBORS];
	logic [CODE_W-1:0]   code_d;
	logic [SAMPLE_W-1:0] centre_scaled;

	assign out_free  = !out_valid_q || out_ready;
	assign s3_free   = !valid_s3 || out_free;
	assign win_ready = s3_free;

	always_comb begin
		logic [SUM_W-1:0] acc;
		for (int n = 0; n < NEIGHBORS; n++) begin
			acc = '0;
			for (int t = 0; t < TAPS; t++) begin
				acc = acc + SUM_W'(TAP_WGT[n][t]) * SUM_W'(win[TAP_IDX[n][t]]);
			end
			sum_d[n] = acc[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= win_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && win_valid) begin
			sum_s3    <= sum_d;
			centre_s3 <= win[CENTRE_IDX];
			tag_s3    <= win_tag;
		end
	end

	// A bit is set when the sample is at least the centre, both at weight scale.
	assign centre_scaled = {centre_s3, {WGT_FRAC{1'b0}}};

	always_comb begin
		code_d = '0;
		for (int n = 0; n < NEIGHBORS; n++) begin
			code_d[n] = (sum_s3[n] >= centre_scaled);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			code_q <= code_d;
			tag_q  <= tag_s3;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_code       = code_q;
	assign out_last_row   = tag_q.last_row;
	assign out_last_frame = tag_q.last_frame;

	a_frame_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tag_q.last_frame) |-> tag_q.last_row)
		else $error("end of frame flagged on a code that does not end a row");

endmodule

/* rtl/circular_lbp_bilinear.sv */
// Top level of the streaming circular local binary pattern block.
`timescale 1ns / 1ps

// Grey pixels enter in raster order on the s_axis channel, one per
// transaction. For every pixel at least one pixel away from each border, one
// 8-bit pattern code leaves on m_axis, with tlast on the final code of a row
// and tuser on the final code of the frame. Border pixels produce nothing.
// The code for a centre pixel is sent when the pixel one row below and one
// column right of it has been taken.
// Frame size is set through the write port (index 0: width, index 1: height),
// clamped to 3..1024 and 3..4096; any write restarts the frame count. Write
// only while the block is idle.
// Throughput is one pixel per clock until a receiver stall fills the
// pipeline. After the transaction of the pixel that completes a code, the
// line store read shares the edge of the transaction, then follow the window
// shift, the sample sums and the compare into the output register, all
// registered. The line store is a single RAM read and written once per pixel.
// Reset sets 640 x 480, clears the counters and window and leaves the line
// store as it is; no clearing pass is needed, rows are written before read.
// When the receiver stalls, the pipeline keeps taking pixels until its four
// stages are full, then drops s_axis_tready.
module circular_lbp_bilinear (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [clbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clbp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // [7:0] lbp_code
	output logic                          m_axis_tlast,  // last_in_row
	output logic                          m_axis_tuser   // [0] last_in_frame
);

	import clbp_pkg::*;

	logic win_valid;
	logic win_ready;
	win_t win;
	tag_t win_tag;

	clbp_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pixel  (s_axis_tdata),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win),
		.win_tag   (win_tag)
	);

	clbp_sample u_sample (
		.clk            (clk),
		.arst_n         (arst_n),
		.win_valid      (win_valid),
		.win_ready      (win_ready),
		.win            (win),
		.win_tag        (win_tag),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_code       (m_axis_tdata),
		.out_last_row   (m_axis_tlast),
		.out_last_frame (m_axis_tuser)
	);

endmodule

/* bench/tb_circular_lbp_bilinear.sv */
// Self-checking testbench for the streaming circular LBP block with bilinear sampling.
`timescale 1ns / 1ps

module tb_circular_lbp_bilinear;
	import clbp_pkg::*;

	localparam string BLOCK_TAG    = "[circular_lbp_bilinear]";
	localparam int    RING_RADIUS  = (SPAN - 1) / 2;
	localparam int    SETTLE_CYCLES = 8;
	localparam int    QUIET_LIMIT  = 1000;
	localparam int    RANDOM_ITEMS = 600;

	// Sine and cosine of 2*pi*n/8 in signed Q16.
	localparam int CIRC_SIN [NEIGHBORS] = '{0, 46341, 65536, 46341, 0, -46341, -65536, -46341};
	localparam int CIRC_COS [NEIGHBORS] = '{65536, 46341, 0, -46341, -65536, -46341, 0, 46341};

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              row_end;
		logic              frame_end;
	} lbp_result_t;

	typedef struct packed {
		pix_t        px;
		logic        typed;
		lbp_result_t res;
	} probe_t;

	typedef enum int {SINK_FLOW, SINK_HOLD, SINK_RANDOM} sink_mode_t;

	localparam lbp_result_t NO_RESULT = '0;

	// Three 3x3 frames: flat, lone bright centre, mixed bit patterns.
	localparam probe_t PROBES [27] = '{
		'{8'h80, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
		'{8'h80, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
		'{8'h80, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
		'{8'h80, 1'b1, '{8'hFF, 1'b1, 1'b1}},
		'{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}},
		'{8'h55, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT}, '{8'h0F, 1'b0, NO_RESULT},
		'{8'hF0, 1'b0, NO_RESULT}, '{8'h7F, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
		'{8'h01, 1'b0, NO_RESULT}, '{8'hFE, 1'b0, NO_RESULT}, '{8'h33, 1'b0, NO_RESULT}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;   // [7:0] pixel
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;        // [7:0] lbp_code
	logic                 m_axis_tlast;
	logic                 m_axis_tuser;        // [0] last_in_frame

	circular_lbp_bilinear dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state.
	int          frame_cols_reg;
	int          frame_rows_reg;
	int          col_pos;
	int          row_pos;
	pix_t        line_mem [STORE_ROWS][MAX_WIDTH];
	pix_t        ring_win [WIN_SIZE];
	int          tap_fx [NEIGHBORS];
	int          tap_cx [NEIGHBORS];
	int          tap_fy [NEIGHBORS];
	int          tap_cy [NEIGHBORS];
	int          tap_wgt [NEIGHBORS][TAPS];

	lbp_result_t expected_codes [$];
	lbp_result_t want;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          burst_left = 0;
	int          pix_base = 128;
	int          sink_left = 0;
	sink_mode_t  sink_mode = SINK_FLOW;

	function automatic int floor_q16(input int q);
		if (q >= 0)
			return q / 65536;
		return -((-q + 65535) / 65536);
	endfunction

	function automatic int round_frac(input int frac);
		return (frac + (1 << (15 - WGT_FRAC))) >> (16 - WGT_FRAC);
	endfunction

	function automatic void reset_model();
		int xq, yq, frx, fry, tx, ty, w4, s, n;
		s = 1 << WGT_FRAC;
		for (n = 0; n < NEIGHBORS; n++) begin
			xq = -RING_RADIUS * CIRC_SIN[n];
			yq = RING_RADIUS * CIRC_COS[n];
			tap_fx[n] = floor_q16(xq);
			tap_fy[n] = floor_q16(yq);
			frx = xq - tap_fx[n] * 65536;
			fry = yq - tap_fy[n] * 65536;
			tap_cx[n] = tap_fx[n] + (frx != 0);
			tap_cy[n] = tap_fy[n] + (fry != 0);
			tx = round_frac(frx);
			ty = round_frac(fry);
			w4 = (tx * ty + (s >> 1)) >> WGT_FRAC;
			tap_wgt[n][0] = s - tx - ty + w4;
			tap_wgt[n][1] = tx - w4;
			tap_wgt[n][2] = ty - w4;
			tap_wgt[n][3] = w4;
		end
		frame_cols_reg = 640;
		frame_rows_reg = 480;
		col_pos = 0;
		row_pos = 0;
		foreach (ring_win[i])
			ring_win[i] = '0;
		foreach (line_mem[k, i])
			line_mem[k][i] = '0;
	endfunction

	function automatic void note_register(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		case (idx)
		REG_IMAGE_WIDTH:  frame_cols_reg = data & 13'h07FF;
		REG_IMAGE_HEIGHT: frame_rows_reg = data & 13'h1FFF;
		default: ;
		endcase
		col_pos = 0;
		row_pos = 0;
	endfunction

	function automatic int tap(input int dy, input int dx);
		return ring_win[(RING_RADIUS + dy) * SPAN + RING_RADIUS + dx];
	endfunction

	// Advances the raster position by one pixel; returns 1 when a code is due.
	function automatic bit lbp_of_pixel(input pix_t px, output lbp_result_t res);
		int w, h, c, r, centre, v, n, y, x, k;
		bit row_end, frame_end, hit;
		w = frame_cols_reg;
		h = frame_rows_reg;
		if (w < SPAN) w = SPAN;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < SPAN) h = SPAN;
		if (h > 4096) h = 4096;
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = row_pos;

		for (y = 0; y < SPAN; y++)
			for (x = 0; x + 1 < SPAN; x++)
				ring_win[y * SPAN + x] = ring_win[y * SPAN + x + 1];
		for (k = 0; k < STORE_ROWS; k++)
			ring_win[k * SPAN + SPAN - 1] = line_mem[k][c];
		ring_win[WIN_SIZE - 1] = px;
		for (k = 0; k + 1 < STORE_ROWS; k++)
			line_mem[k][c] = line_mem[k + 1][c];
		line_mem[STORE_ROWS - 1][c] = px;

		row_end = (c == w - 1);
		frame_end = row_end && (r >= h - 1);
		res = '0;
		hit = 1'b0;
		if (r >= STORE_ROWS && c >= STORE_ROWS) begin
			centre = tap(0, 0) << WGT_FRAC;
			for (n = 0; n < NEIGHBORS; n++) begin
				v = tap_wgt[n][0] * tap(tap_fy[n], tap_fx[n])
				  + tap_wgt[n][1] * tap(tap_fy[n], tap_cx[n])
				  + tap_wgt[n][2] * tap(tap_cy[n], tap_fx[n])
				  + tap_wgt[n][3] * tap(tap_cy[n], tap_cx[n]);
				if (v >= centre)
					res.code[n] = 1'b1;
			end
			res.row_end = row_end;
			res.frame_end = frame_end;
			hit = 1'b1;
		end

		if (row_end) begin
			col_pos = 0;
			row_pos = frame_end ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
		return hit;
	endfunction

	// Noisy flat patches amid black, white and random pixels; samples often hit the centre.
	function automatic pix_t rand_pixel();
		int v;
		case ($urandom_range(0, 5))
		0:       v = 0;
		1:       v = 255;
		2, 3:    v = $urandom_range(0, 255);
		default: v = pix_base + $urandom_range(0, 4) - 2;
		endcase
		if ($urandom_range(0, 31) == 0)
			pix_base = $urandom_range(0, 255);
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return pix_t'(v);
	endfunction

	task automatic push_pixel(input pix_t px, input logic typed, input lbp_result_t typed_res);
		lbp_result_t res;
		bit hit;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		hit = lbp_of_pixel(px, res);
		if (typed)
			expected_codes.push_back(typed_res);
		else if (hit)
			expected_codes.push_back(res);
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic stream_pixels(input int count);
		for (int i = 0; i < count; i++) begin
			push_pixel(rand_pixel(), 1'b0, NO_RESULT);
			pace_sender();
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// Frame size may only change once the pipeline has drained.
	task automatic write_frame_size(input logic [CFG_W-1:0] wdata, input logic [CFG_W-1:0] hdata);
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= wdata;
		note_register(REG_IMAGE_WIDTH, wdata);
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= hdata;
		note_register(REG_IMAGE_HEIGHT, hdata);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 2));
			sink_left = (sink_mode == SINK_HOLD) ? $urandom_range(1, 12) : $urandom_range(1, 40);
		end
		sink_left = sink_left - 1;
		case (sink_mode)
		SINK_FLOW: m_axis_tready <= 1'b1;
		SINK_HOLD: m_axis_tready <= 1'b0;
		default:   m_axis_tready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_codes.size() == 0) begin
				$error("unexpected transaction: lbp_code %0h", m_axis_tdata);
				mismatches++;
			end else begin
				want = expected_codes.pop_front();
				if (m_axis_tdata !== want.code) begin
					$error("lbp_code: expected %0h, got %0h", want.code, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tlast !== want.row_end) begin
					$error("last_in_row: expected %0b, got %0b", want.row_end, m_axis_tlast);
					mismatches++;
				end
				if (m_axis_tuser !== want.frame_end) begin
					$error("last_in_frame: expected %0b, got %0b", want.frame_end, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("[circular_lbp_bilinear] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int random_count, w, h, count;
		logic [CFG_W-1:0] wdata, hdata;
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// At the reset size of 640 columns a short stream stays in the first row and gives no code.
		stream_pixels(64);

		// Register values below the minimum clamp to a 3x3 frame.
		write_frame_size(13'd0, 13'd2);
		for (int i = 0; i < $size(PROBES); i++) begin
			push_pixel(PROBES[i].px, PROBES[i].typed, PROBES[i].res);
			pace_sender();
		end
		s_axis_tvalid <= 1'b0;

		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			w = $urandom_range(3, 12);
			h = $urandom_range(3, 8);
			wdata = CFG_W'(w);
			hdata = CFG_W'(h);
			if ($urandom_range(0, 7) == 0) begin
				wdata = CFG_W'($urandom_range(0, 2));
				w = 3;
			end
			if ($urandom_range(0, 7) == 0) begin
				hdata = CFG_W'($urandom_range(0, 2));
				h = 3;
			end
			// Bits above the 11-bit width register are dropped.
			if ($urandom_range(0, 5) == 0)
				wdata = wdata | 13'h1800;
			count = $urandom_range(1, 3) * w * h + $urandom_range(0, w * h - 1);
			write_frame_size(wdata, hdata);
			stream_pixels(count);
			random_count += count;
		end

		// Widest row: the width register saturates at the line store depth, so no row ends here.
		write_frame_size(13'h1FFF, 13'd3);
		stream_pixels(40);

		// Tallest frame on a narrow row: its codes carry no end of frame.
		write_frame_size(13'd3, 13'h1FFF);
		stream_pixels(3 * 40);

		while (expected_codes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("[circular_lbp_bilinear] OK");
		else
			$display("[circular_lbp_bilinear] ERROR");
		$finish;
	end

endmodule
